// ===== rtl/psopu_pkg.sv =====
// Shared types and constants for the particle update block.
package psopu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int RAND_BITS = 16;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_MOVE   = 2'd1;
    localparam logic [1:0] OP_SCORE  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] REG_COG   = 3'd0;
    localparam logic [2:0] REG_SOC   = 3'd1;
    localparam logic [2:0] REG_STEPS = 3'd2;
    localparam logic [2:0] REG_LB0   = 3'd3;
    localparam logic [2:0] REG_UB0   = 3'd4;
    localparam logic [2:0] REG_LB1   = 3'd5;
    localparam logic [2:0] REG_UB1   = 3'd6;

    localparam logic [15:0] W_HIGH = 16'd58982;   // 0.9 rounded
    localparam logic [15:0] W_LOW  = 16'd26214;   // 0.4 rounded
    localparam logic signed [31:0] LOSS_INIT = 32'sd5898240;  // 90.0
    localparam logic signed [31:0] BOUND_INIT = 32'sd655360;  // 10.0
    localparam logic [18:0] GAIN_INIT = 19'd131072;
    localparam logic [15:0] STEPS_INIT = 16'd100;

    typedef enum logic [2:0] {
        M_GC, M_GS, M_WV, M_PC, M_PS, M_VEL, M_RD
    } mop_t;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_WINIT, S_DIV, S_MUL, S_CHECK, S_RD, S_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic winit;
        logic div_step;
        logic mul_en;
        mop_t mop;
        logic dim;
        logic check;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       clamp;
        logic       in_bounds;
        logic       out_busy;
    } status_t;

endpackage

// ===== rtl/psopu_ctrl.sv =====
// Controller state machine: sequences divide, multiply steps and result handoff.
module psopu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  psopu_pkg::status_t sts,
    output psopu_pkg::cmd_t    cmd
);

    psopu_pkg::state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       dim_reg, dim_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psopu_pkg::S_IDLE;
            cnt_reg   <= 4'd0;
            dim_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dim_reg   <= dim_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dim_next   = dim_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mop    = psopu_pkg::M_GC;
        cmd.dim    = dim_reg;
        unique case (state_reg)
            psopu_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    state_next = psopu_pkg::S_EXEC;
                end
            end
            psopu_pkg::S_EXEC:
            begin
                if (sts.op == psopu_pkg::OP_MOVE)
                begin
                    state_next = psopu_pkg::S_WINIT;
                end
                else
                begin
                    cmd.exec = 1'b1;
                    state_next = psopu_pkg::S_DONE;
                end
            end
            psopu_pkg::S_WINIT:
            begin
                cmd.winit = 1'b1;
                cnt_next  = 4'd0;
                dim_next  = 1'b0;
                state_next = sts.clamp ? psopu_pkg::S_MUL : psopu_pkg::S_DIV;
            end
            psopu_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    cnt_next = 4'd0;
                    state_next = psopu_pkg::S_MUL;
                end
            end
            psopu_pkg::S_MUL:
            begin
                cmd.mul_en = 1'b1;
                unique case (cnt_reg)
                    4'd0: cmd.mop = psopu_pkg::M_GC;
                    4'd1: cmd.mop = psopu_pkg::M_GS;
                    4'd2: cmd.mop = psopu_pkg::M_WV;
                    4'd3: cmd.mop = psopu_pkg::M_PC;
                    4'd4: cmd.mop = psopu_pkg::M_PS;
                    default: cmd.mop = psopu_pkg::M_VEL;
                endcase
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd5)
                begin
                    cnt_next = 4'd0;
                    dim_next = 1'b1;
                    if (dim_reg)
                    begin
                        dim_next = 1'b0;
                        state_next = psopu_pkg::S_CHECK;
                    end
                end
            end
            psopu_pkg::S_CHECK:
            begin
                cmd.check = 1'b1;
                dim_next = 1'b0;
                state_next = sts.in_bounds ? psopu_pkg::S_DONE : psopu_pkg::S_RD;
            end
            psopu_pkg::S_RD:
            begin
                cmd.mul_en = 1'b1;
                cmd.mop = psopu_pkg::M_RD;
                dim_next = 1'b1;
                if (dim_reg)
                begin
                    dim_next = 1'b0;
                    state_next = psopu_pkg::S_DONE;
                end
            end
            psopu_pkg::S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = psopu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = psopu_pkg::S_IDLE;
            end
        endcase
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == psopu_pkg::S_EXEC)
        else $error("accepted transaction did not start");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == psopu_pkg::S_DIV && cnt_reg == 4'd15 |=> state_reg == psopu_pkg::S_MUL)
        else $error("divide did not end after 16 steps");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("result loaded over pending result");

endmodule

// ===== rtl/psopu_dp.sv =====
// Datapath: particle state, config registers, shared multiplier, divider, result register.
module psopu_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  psopu_pkg::cmd_t    cmd,
    output psopu_pkg::status_t sts,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic [1:0]         opcode,
    input  logic [15:0]        step_index,
    input  logic [16:0]        rand_cog_0,
    input  logic [16:0]        rand_cog_1,
    input  logic [16:0]        rand_soc_0,
    input  logic [16:0]        rand_soc_1,
    input  logic [16:0]        rand_redraw_0,
    input  logic [16:0]        rand_redraw_1,
    input  logic signed [31:0] guide_pos_0,
    input  logic signed [31:0] guide_pos_1,
    input  logic signed [31:0] loss_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] position_0,
    output logic signed [31:0] position_1,
    output logic signed [31:0] best_pos_0,
    output logic signed [31:0] best_pos_1,
    output logic signed [31:0] best_loss,
    output logic               redrawn,
    output logic               improved
);

    // configuration
    logic [18:0] cog_reg, soc_reg;
    logic [15:0] steps_reg;
    logic signed [31:0] lb_reg [2];
    logic signed [31:0] ub_reg [2];

    // particle state
    logic signed [31:0] pos_reg [2];
    logic signed [31:0] vel_reg [2];
    logic signed [31:0] bp_reg [2];
    logic signed [31:0] bl_reg;

    // captured transaction
    logic [1:0]  op_reg;
    logic [15:0] t_reg;
    logic [16:0] rc_reg [2];
    logic [16:0] rs_reg [2];
    logic [16:0] rr_reg [2];
    logic signed [31:0] gd_reg [2];
    logic signed [31:0] loss_reg;

    // work registers
    logic [15:0] w_reg, rem_reg;
    logic [19:0] gc_reg, gs_reg;
    logic signed [40:0] acc_reg;
    logic signed [31:0] nxt_reg [2];
    logic inside_reg, redrawn_reg, improved_reg, ovalid_reg;
    logic signed [31:0] opos_reg [2];
    logic signed [31:0] obp_reg [2];
    logic signed [31:0] obl_reg;
    logic oredrawn_reg, oimproved_reg;

    logic d;
    assign d = cmd.dim;

    // inertia weight setup
    logic [15:0] n_val;
    logic signed [17:0] num;
    logic signed [21:0] ten_num, nine_n, four_n;
    logic clamp_hi, clamp_lo;
    logic [16:0] r2;

    assign n_val   = (steps_reg == 16'd0) ? 16'd1 : steps_reg;
    assign num     = $signed({2'b00, n_val}) - $signed({2'b00, t_reg});
    assign ten_num = ({{4{num[17]}}, num} <<< 3) + ({{4{num[17]}}, num} <<< 1);
    assign nine_n  = $signed({3'b000, n_val, 3'b000}) + $signed({6'd0, n_val});
    assign four_n  = $signed({4'd0, n_val, 2'b00});
    assign clamp_hi = ten_num > nine_n;
    assign clamp_lo = ten_num < four_n;
    assign r2 = {rem_reg, 1'b0};

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [54:0] prod;
    logic signed [38:0] prod_sh;
    logic signed [33:0] diff_c, diff_s, span;

    assign diff_c = {{2{bp_reg[d][31]}}, bp_reg[d]} - {{2{pos_reg[d][31]}}, pos_reg[d]};
    assign diff_s = {{2{gd_reg[d][31]}}, gd_reg[d]} - {{2{pos_reg[d][31]}}, pos_reg[d]};
    assign span   = {{2{ub_reg[d][31]}}, ub_reg[d]} - {{2{lb_reg[d][31]}}, lb_reg[d]};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mop)
            psopu_pkg::M_GC:
            begin
                mul_a = $signed({15'd0, cog_reg});
                mul_b = $signed({4'd0, rc_reg[d]});
            end
            psopu_pkg::M_GS:
            begin
                mul_a = $signed({15'd0, soc_reg});
                mul_b = $signed({4'd0, rs_reg[d]});
            end
            psopu_pkg::M_WV:
            begin
                mul_a = {{2{vel_reg[d][31]}}, vel_reg[d]};
                mul_b = $signed({5'd0, w_reg});
            end
            psopu_pkg::M_PC:
            begin
                mul_a = diff_c;
                mul_b = $signed({1'b0, gc_reg});
            end
            psopu_pkg::M_PS:
            begin
                mul_a = diff_s;
                mul_b = $signed({1'b0, gs_reg});
            end
            psopu_pkg::M_RD:
            begin
                mul_a = span;
                mul_b = $signed({4'd0, rr_reg[d]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign prod_sh = prod[54:16];

    // velocity saturation and bound test
    logic signed [31:0] vsat;
    logic signed [32:0] nxt_w;
    logic in_range;
    logic signed [39:0] rd_sum;
    logic signed [31:0] rd_sat;

    always_comb
    begin
        if (acc_reg > 41'sd2147483647)
        begin
            vsat = 32'sh7fffffff;
        end
        else if (acc_reg < -41'sd2147483648)
        begin
            vsat = 32'sh80000000;
        end
        else
        begin
            vsat = acc_reg[31:0];
        end
        nxt_w = {vsat[31], vsat} + {pos_reg[d][31], pos_reg[d]};
        in_range = (nxt_w > $signed({lb_reg[d][31], lb_reg[d]}))
                && (nxt_w < $signed({ub_reg[d][31], ub_reg[d]}));
        rd_sum = {{8{lb_reg[d][31]}}, lb_reg[d]} + {prod_sh[38], prod_sh};
        if (rd_sum > 40'sd2147483647)
        begin
            rd_sat = 32'sh7fffffff;
        end
        else if (rd_sum < -40'sd2147483648)
        begin
            rd_sat = 32'sh80000000;
        end
        else
        begin
            rd_sat = rd_sum[31:0];
        end
    end

    // configuration and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cog_reg   <= psopu_pkg::GAIN_INIT;
            soc_reg   <= psopu_pkg::GAIN_INIT;
            steps_reg <= psopu_pkg::STEPS_INIT;
            lb_reg[0] <= -psopu_pkg::BOUND_INIT;
            ub_reg[0] <= psopu_pkg::BOUND_INIT;
            lb_reg[1] <= -psopu_pkg::BOUND_INIT;
            ub_reg[1] <= psopu_pkg::BOUND_INIT;
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            vel_reg[0] <= '0;
            vel_reg[1] <= '0;
            bp_reg[0]  <= '0;
            bp_reg[1]  <= '0;
            bl_reg     <= psopu_pkg::LOSS_INIT;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    psopu_pkg::REG_COG:   cog_reg   <= cfg_wdata[18:0];
                    psopu_pkg::REG_SOC:   soc_reg   <= cfg_wdata[18:0];
                    psopu_pkg::REG_STEPS: steps_reg <= cfg_wdata[15:0];
                    psopu_pkg::REG_LB0:   lb_reg[0] <= cfg_wdata;
                    psopu_pkg::REG_UB0:   ub_reg[0] <= cfg_wdata;
                    psopu_pkg::REG_LB1:   lb_reg[1] <= cfg_wdata;
                    psopu_pkg::REG_UB1:   ub_reg[1] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.exec)
            begin
                if (op_reg == psopu_pkg::OP_LOAD)
                begin
                    pos_reg[0] <= gd_reg[0];
                    pos_reg[1] <= gd_reg[1];
                    vel_reg[0] <= '0;
                    vel_reg[1] <= '0;
                    bp_reg[0]  <= gd_reg[0];
                    bp_reg[1]  <= gd_reg[1];
                    bl_reg     <= psopu_pkg::LOSS_INIT;
                end
                else if (op_reg == psopu_pkg::OP_SCORE && loss_reg < bl_reg)
                begin
                    bl_reg    <= loss_reg;
                    bp_reg[0] <= pos_reg[0];
                    bp_reg[1] <= pos_reg[1];
                end
            end
            if (cmd.mul_en && cmd.mop == psopu_pkg::M_VEL)
            begin
                vel_reg[d] <= vsat;
            end
            if (cmd.check && inside_reg)
            begin
                pos_reg[0] <= nxt_reg[0];
                pos_reg[1] <= nxt_reg[1];
            end
            if (cmd.mul_en && cmd.mop == psopu_pkg::M_RD)
            begin
                pos_reg[d] <= rd_sat;
            end
            if (cmd.out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= opcode;
            t_reg     <= step_index;
            rc_reg[0] <= rand_cog_0;
            rc_reg[1] <= rand_cog_1;
            rs_reg[0] <= rand_soc_0;
            rs_reg[1] <= rand_soc_1;
            rr_reg[0] <= rand_redraw_0;
            rr_reg[1] <= rand_redraw_1;
            gd_reg[0] <= guide_pos_0;
            gd_reg[1] <= guide_pos_1;
            loss_reg  <= loss_value;
            redrawn_reg  <= 1'b0;
            improved_reg <= 1'b0;
        end
        if (cmd.exec && op_reg == psopu_pkg::OP_SCORE && loss_reg < bl_reg)
        begin
            improved_reg <= 1'b1;
        end
        if (cmd.winit)
        begin
            inside_reg <= 1'b1;
            rem_reg    <= num[15:0];
            if (clamp_hi)
            begin
                w_reg <= psopu_pkg::W_HIGH;
            end
            else if (clamp_lo)
            begin
                w_reg <= psopu_pkg::W_LOW;
            end
            else
            begin
                w_reg <= '0;
            end
        end
        if (cmd.div_step)
        begin
            if (r2 >= {1'b0, n_val})
            begin
                rem_reg <= 16'(r2 - {1'b0, n_val});
                w_reg   <= {w_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= r2[15:0];
                w_reg   <= {w_reg[14:0], 1'b0};
            end
        end
        if (cmd.mul_en)
        begin
            unique case (cmd.mop)
                psopu_pkg::M_GC: gc_reg <= prod[35:16];
                psopu_pkg::M_GS: gs_reg <= prod[35:16];
                psopu_pkg::M_WV: acc_reg <= {{2{prod_sh[38]}}, prod_sh};
                psopu_pkg::M_PC: acc_reg <= acc_reg + {{2{prod_sh[38]}}, prod_sh};
                psopu_pkg::M_PS: acc_reg <= acc_reg + {{2{prod_sh[38]}}, prod_sh};
                psopu_pkg::M_VEL:
                begin
                    nxt_reg[d] <= nxt_w[31:0];
                    inside_reg <= inside_reg & in_range;
                end
                default: ;
            endcase
        end
        if (cmd.check && !inside_reg)
        begin
            redrawn_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            opos_reg[0]   <= pos_reg[0];
            opos_reg[1]   <= pos_reg[1];
            obp_reg[0]    <= bp_reg[0];
            obp_reg[1]    <= bp_reg[1];
            obl_reg       <= bl_reg;
            oredrawn_reg  <= redrawn_reg;
            oimproved_reg <= improved_reg;
        end
    end

    assign sts.op        = op_reg;
    assign sts.clamp     = clamp_hi | clamp_lo;
    assign sts.in_bounds = inside_reg;
    assign sts.out_busy  = ovalid_reg & ~out_ready;

    assign out_valid  = ovalid_reg;
    assign position_0 = opos_reg[0];
    assign position_1 = opos_reg[1];
    assign best_pos_0 = obp_reg[0];
    assign best_pos_1 = obp_reg[1];
    assign best_loss  = obl_reg;
    assign redrawn    = oredrawn_reg;
    assign improved   = oimproved_reg;

endmodule

// ===== rtl/particle_swarm_particle_update_top.sv =====
// Top level of the particle update block: controller plus datapath.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | opcode .. loss_value
//  out     | output    | out_valid/out_ready | position_0 .. improved
//  cfg     | input     | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// One transaction at a time. Load, score and unused opcodes go through the execute and done states;
// a move runs a 16-step restoring divide for the inertia weight (skipped when the
// weight clamps) and 12 steps on one shared 34x21 multiplier, plus 2 more when the
// position is redrawn. A new transaction is accepted while the result waits.
// Reset puts the particle at the origin with best loss 90 and default registers.
// A stalled output holds the block in its final state until the result register frees.
module particle_swarm_particle_update_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [15:0]        step_index,
    input  logic [16:0]        rand_cog_0,
    input  logic [16:0]        rand_cog_1,
    input  logic [16:0]        rand_soc_0,
    input  logic [16:0]        rand_soc_1,
    input  logic [16:0]        rand_redraw_0,
    input  logic [16:0]        rand_redraw_1,
    input  logic signed [31:0] guide_pos_0,
    input  logic signed [31:0] guide_pos_1,
    input  logic signed [31:0] loss_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] position_0,
    output logic signed [31:0] position_1,
    output logic signed [31:0] best_pos_0,
    output logic signed [31:0] best_pos_1,
    output logic signed [31:0] best_loss,
    output logic               redrawn,
    output logic               improved
);

    psopu_pkg::cmd_t    cmd;
    psopu_pkg::status_t sts;

    psopu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    psopu_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .opcode        (opcode),
        .step_index    (step_index),
        .rand_cog_0    (rand_cog_0),
        .rand_cog_1    (rand_cog_1),
        .rand_soc_0    (rand_soc_0),
        .rand_soc_1    (rand_soc_1),
        .rand_redraw_0 (rand_redraw_0),
        .rand_redraw_1 (rand_redraw_1),
        .guide_pos_0   (guide_pos_0),
        .guide_pos_1   (guide_pos_1),
        .loss_value    (loss_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .position_0    (position_0),
        .position_1    (position_1),
        .best_pos_0    (best_pos_0),
        .best_pos_1    (best_pos_1),
        .best_loss     (best_loss),
        .redrawn       (redrawn),
        .improved      (improved)
    );

endmodule

// ===== tb/sv/particle_swarm_particle_update_top_tb.sv =====
// Testbench for the particle update block: queued stimulus, clocked driver/monitor, scoreboard.
`timescale 1ns / 1ps

module particle_swarm_particle_update_top_tb;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] step;
        logic [16:0] rc0, rc1, rs0, rs1, rr0, rr1;
        logic [31:0] g0, g1, loss;
    } pitem_t;

    typedef struct {
        logic [31:0] p0, p1, b0, b1, bl;
        logic        rd, imp;
    } pstate_t;

    localparam int WATCHDOG = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [1:0]  opcode = '0;
    logic [15:0] step_index = '0;
    logic [16:0] rand_cog_0 = '0, rand_cog_1 = '0, rand_soc_0 = '0, rand_soc_1 = '0;
    logic [16:0] rand_redraw_0 = '0, rand_redraw_1 = '0;
    logic signed [31:0] guide_pos_0 = '0, guide_pos_1 = '0, loss_value = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic signed [31:0] position_0, position_1, best_pos_0, best_pos_1, best_loss;
    logic        redrawn, improved;

    particle_swarm_particle_update_top uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // predictor state and register copies
    longint m_pos[2], m_vel[2], m_best[2], m_bval;
    longint m_cog, m_soc, m_steps, m_lb[2], m_ub[2];

    pitem_t  pending[$];
    pstate_t expected_state[$];
    int      errors = 0;
    int      idle_cycles = 0;
    bit      drive_hold = 0;

    function automatic longint fshift(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint sx(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint inertia_weight(longint t);
        longint n, num;
        n = (m_steps == 0) ? 1 : m_steps;
        num = n - t;
        if (10 * num > 9 * n) return longint'(psopu_pkg::W_HIGH);
        if (10 * num < 4 * n) return longint'(psopu_pkg::W_LOW);
        return (num <<< psopu_pkg::FRAC_BITS) / n;
    endfunction

    function automatic longint pull_term(longint gain, longint frac, longint diff);
        longint g;
        g = (gain * frac) >>> psopu_pkg::RAND_BITS;
        return fshift(g * diff, psopu_pkg::FRAC_BITS);
    endfunction

    task automatic predict_update(input pitem_t it);
        pstate_t r;
        longint  w, v, nxt[2], rc[2], rs[2], rr[2], gd[2], span;
        bit      in_bounds;
        rc = '{longint'(it.rc0), longint'(it.rc1)};
        rs = '{longint'(it.rs0), longint'(it.rs1)};
        rr = '{longint'(it.rr0), longint'(it.rr1)};
        gd = '{sx(it.g0), sx(it.g1)};
        r.rd = 0;
        r.imp = 0;
        if (it.op == psopu_pkg::OP_LOAD)
        begin
            for (int i = 0; i < 2; i++)
            begin
                m_pos[i] = gd[i];
                m_vel[i] = 0;
                m_best[i] = gd[i];
            end
            m_bval = longint'(psopu_pkg::LOSS_INIT);
        end
        else if (it.op == psopu_pkg::OP_MOVE)
        begin
            w = inertia_weight(longint'(it.step));
            in_bounds = 1;
            for (int i = 0; i < 2; i++)
            begin
                v = fshift(w * m_vel[i], psopu_pkg::FRAC_BITS)
                    + pull_term(m_cog, rc[i], m_best[i] - m_pos[i])
                    + pull_term(m_soc, rs[i], gd[i] - m_pos[i]);
                m_vel[i] = sat32(v);
                nxt[i] = m_pos[i] + m_vel[i];
                if (!(nxt[i] > m_lb[i] && nxt[i] < m_ub[i])) in_bounds = 0;
            end
            for (int i = 0; i < 2; i++)
            begin
                if (in_bounds) m_pos[i] = nxt[i];
                else
                begin
                    span = m_ub[i] - m_lb[i];
                    m_pos[i] = sat32(m_lb[i] + fshift(rr[i] * span, psopu_pkg::RAND_BITS));
                end
            end
            r.rd = !in_bounds;
        end
        else if (it.op == psopu_pkg::OP_SCORE)
        begin
            if (sx(it.loss) < m_bval)
            begin
                m_bval = sx(it.loss);
                m_best = m_pos;
                r.imp = 1;
            end
        end
        r.p0 = m_pos[0][31:0];
        r.p1 = m_pos[1][31:0];
        r.b0 = m_best[0][31:0];
        r.b1 = m_best[1][31:0];
        r.bl = m_bval[31:0];
        expected_state.push_back(r);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            psopu_pkg::REG_COG:   m_cog = longint'(val[18:0]);
            psopu_pkg::REG_SOC:   m_soc = longint'(val[18:0]);
            psopu_pkg::REG_STEPS: m_steps = longint'(val[15:0]);
            psopu_pkg::REG_LB0:   m_lb[0] = sx(val);
            psopu_pkg::REG_UB0:   m_ub[0] = sx(val);
            psopu_pkg::REG_LB1:   m_lb[1] = sx(val);
            psopu_pkg::REG_UB1:   m_ub[1] = sx(val);
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [16:0] rand_frac();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 1600000)) - 800000);
        endcase
    endfunction

    function automatic pitem_t rand_item(input logic [1:0] op);
        pitem_t it;
        it.op = op;
        it.step = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, 150));
        it.rc0 = rand_frac(); it.rc1 = rand_frac();
        it.rs0 = rand_frac(); it.rs1 = rand_frac();
        it.rr0 = rand_frac(); it.rr1 = rand_frac();
        it.g0 = rand_coord(); it.g1 = rand_coord();
        it.loss = ($urandom_range(0, 3) == 0) ? $urandom
                  : 32'($signed($urandom_range(0, 7000000)) - 500000);
        return it;
    endfunction

    function automatic pitem_t fixed_item(input logic [1:0] op, input logic [15:0] st,
        input logic [16:0] fr, input logic [31:0] g0, input logic [31:0] g1,
        input logic [31:0] loss);
        pitem_t it;
        it.op = op; it.step = st;
        it.rc0 = fr; it.rc1 = fr; it.rs0 = fr; it.rs1 = fr; it.rr0 = fr; it.rr1 = fr;
        it.g0 = g0; it.g1 = g1; it.loss = loss;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending.size() != 0 || in_valid || expected_state.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // driver
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            predict_update(pending.pop_front());
            send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        end
        if (!(in_valid && !in_ready))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 0;
            end
            else if (pending.size() != 0 && !drive_hold)
            begin
                in_valid <= 1;
                opcode <= pending[0].op;
                step_index <= pending[0].step;
                rand_cog_0 <= pending[0].rc0; rand_cog_1 <= pending[0].rc1;
                rand_soc_0 <= pending[0].rs0; rand_soc_1 <= pending[0].rs1;
                rand_redraw_0 <= pending[0].rr0; rand_redraw_1 <= pending[0].rr1;
                guide_pos_0 <= pending[0].g0; guide_pos_1 <= pending[0].g1;
                loss_value <= pending[0].loss;
            end
            else
                in_valid <= 0;
        end
    end

    // monitor
    int recv_gap = 0;
    always @(posedge clk)
    begin
        pstate_t e;
        if (out_valid && out_ready)
        begin
            idle_cycles <= 0;
            if (expected_state.size() == 0)
            begin
                $display("unexpected result transaction at %0t", $realtime);
                errors++;
            end
            else
            begin
                e = expected_state.pop_front();
                if (position_0 !== e.p0) report_mismatch("position_0", position_0, e.p0);
                if (position_1 !== e.p1) report_mismatch("position_1", position_1, e.p1);
                if (best_pos_0 !== e.b0) report_mismatch("best_pos_0", best_pos_0, e.b0);
                if (best_pos_1 !== e.b1) report_mismatch("best_pos_1", best_pos_1, e.b1);
                if (best_loss !== e.bl) report_mismatch("best_loss", best_loss, e.bl);
                if (redrawn !== e.rd) report_mismatch("redrawn", redrawn, e.rd);
                if (improved !== e.imp) report_mismatch("improved", improved, e.imp);
            end
            recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        end
        else if (in_valid && in_ready)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 0;
        end
        else
            out_ready <= 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && idle_cycles >= WATCHDOG)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [1:0] op;
        m_cog = longint'(psopu_pkg::GAIN_INIT); m_soc = longint'(psopu_pkg::GAIN_INIT);
        m_steps = longint'(psopu_pkg::STEPS_INIT);
        m_lb = '{-longint'(psopu_pkg::BOUND_INIT), -longint'(psopu_pkg::BOUND_INIT)};
        m_ub = '{longint'(psopu_pkg::BOUND_INIT), longint'(psopu_pkg::BOUND_INIT)};
        m_pos = '{0, 0}; m_vel = '{0, 0}; m_best = '{0, 0};
        m_bval = longint'(psopu_pkg::LOSS_INIT);
        repeat (5) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // directed: reset defaults, extremes, each opcode and the odd cases
        pending.push_back(fixed_item(psopu_pkg::OP_MOVE, 16'd0, 17'd65536, 32'h0002_0000,
                                     32'hFFFE_0000, 32'd0));
        pending.push_back(fixed_item(psopu_pkg::OP_SCORE, 16'd0, 17'd0, 32'd0, 32'd0,
                                     32'h8000_0000));
        pending.push_back(fixed_item(psopu_pkg::OP_SCORE, 16'd0, 17'd0, 32'd0, 32'd0,
                                     32'h7FFF_FFFF));
        pending.push_back(fixed_item(psopu_pkg::OP_LOAD, 16'd0, 17'd0, 32'h0001_0000,
                                     32'hFFFF_8000, 32'd0));
        pending.push_back(fixed_item(psopu_pkg::OP_MOVE, 16'd50, 17'h1FFFF, 32'h7FFF_FFFF,
                                     32'h8000_0000, 32'd0));
        pending.push_back(fixed_item(psopu_pkg::OP_MOVE, 16'hFFFF, 17'd32768, 32'h0003_0000,
                                     32'h0001_0000, 32'd0));
        pending.push_back(fixed_item(psopu_pkg::OP_MOVE, 16'd101, 17'd1000, 32'd0, 32'd0,
                                     32'd0));
        pending.push_back(fixed_item(psopu_pkg::OP_UNUSED, 16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending.push_back(fixed_item(psopu_pkg::OP_SCORE, 16'd0, 17'd0, 32'd0, 32'd0,
                                     32'h0000_1000));
        pending.push_back(fixed_item(psopu_pkg::OP_SCORE, 16'd0, 17'd0, 32'd0, 32'd0,
                                     32'h0000_1000));
        wait_drained();

        // zero step count, reversed bounds, maximal cognitive gain
        write_reg(psopu_pkg::REG_STEPS, 32'd0);
        write_reg(psopu_pkg::REG_COG, 32'h7FFFF);
        write_reg(psopu_pkg::REG_SOC, 32'd262144);
        write_reg(psopu_pkg::REG_LB0, 32'h7FFF_FFFF);
        write_reg(psopu_pkg::REG_UB0, 32'h8000_0000);
        write_reg(psopu_pkg::REG_LB1, 32'h0001_0000);
        write_reg(psopu_pkg::REG_UB1, 32'h0001_0000);
        pending.push_back(fixed_item(psopu_pkg::OP_MOVE, 16'd0, 17'h1FFFF, 32'h1234_5678,
                                     32'h8765_4321, 32'd0));
        pending.push_back(fixed_item(psopu_pkg::OP_MOVE, 16'd1, 17'd0, 32'd0, 32'd0, 32'd0));
        pending.push_back(fixed_item(psopu_pkg::OP_MOVE, 16'd5, 17'd65536, 32'd0, 32'd0,
                                     32'd0));
        wait_drained();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(psopu_pkg::REG_COG, 32'd131072);
                    write_reg(psopu_pkg::REG_SOC, 32'd131072);
                    write_reg(psopu_pkg::REG_STEPS, 32'd100);
                    write_reg(psopu_pkg::REG_LB0, 32'hFFF6_0000);
                    write_reg(psopu_pkg::REG_UB0, 32'h000A_0000);
                    write_reg(psopu_pkg::REG_LB1, 32'hFFF6_0000);
                    write_reg(psopu_pkg::REG_UB1, 32'h000A_0000);
                end
                1:
                begin
                    write_reg(psopu_pkg::REG_COG, 32'd0);
                    write_reg(psopu_pkg::REG_SOC, 32'd262144);
                    write_reg(psopu_pkg::REG_STEPS, 32'd1);
                end
                2:
                begin
                    write_reg(psopu_pkg::REG_STEPS, 32'd65535);
                    write_reg(psopu_pkg::REG_LB0, 32'h8000_0000);
                    write_reg(psopu_pkg::REG_UB0, 32'h7FFF_FFFF);
                    write_reg(psopu_pkg::REG_LB1, 32'h8000_0000);
                    write_reg(psopu_pkg::REG_UB1, 32'h7FFF_FFFF);
                end
                3:
                begin
                    write_reg(psopu_pkg::REG_COG, 32'd262144);
                    write_reg(psopu_pkg::REG_SOC, 32'd0);
                    write_reg(psopu_pkg::REG_STEPS, 32'd37);
                    write_reg(psopu_pkg::REG_LB0, 32'hFFFE_0000);
                    write_reg(psopu_pkg::REG_UB0, 32'h0005_0000);
                    write_reg(psopu_pkg::REG_LB1, 32'hFFFF_0000);
                    write_reg(psopu_pkg::REG_UB1, 32'h0001_0000);
                end
                4:
                begin
                    write_reg(psopu_pkg::REG_COG, 32'($urandom_range(0, 262144)));
                    write_reg(psopu_pkg::REG_SOC, 32'($urandom_range(0, 262144)));
                    write_reg(psopu_pkg::REG_STEPS, 32'($urandom_range(1, 300)));
                    write_reg(psopu_pkg::REG_LB0, 32'h0003_0000);
                    write_reg(psopu_pkg::REG_UB0, 32'hFFFD_0000);
                end
                default:
                begin
                    write_reg(psopu_pkg::REG_COG, 32'd98304);
                    write_reg(psopu_pkg::REG_SOC, 32'd98304);
                    write_reg(psopu_pkg::REG_STEPS, 32'd200);
                    write_reg(psopu_pkg::REG_LB0, 32'hFFEC_0000);
                    write_reg(psopu_pkg::REG_UB0, 32'h0014_0000);
                    write_reg(psopu_pkg::REG_LB1, 32'hFFEC_0000);
                    write_reg(psopu_pkg::REG_UB1, 32'h0014_0000);
                end
            endcase
            for (int k = 0; k < 270; k++)
            begin
                case ($urandom_range(0, 19))
                    0, 1:        op = psopu_pkg::OP_LOAD;
                    2, 3, 4, 5:  op = psopu_pkg::OP_SCORE;
                    6:           op = psopu_pkg::OP_UNUSED;
                    default:     op = psopu_pkg::OP_MOVE;
                endcase
                pending.push_back(rand_item(op));
                // hold the sender until the pipe is empty once per phase
                if (k == 135)
                begin
                    while (pending.size() != 0 || in_valid) @(posedge clk);
                    drive_hold = 1;
                    while (expected_state.size() != 0) @(posedge clk);
                    drive_hold = 0;
                end
            end
            wait_drained();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/psopu_pkg.sv
rtl/psopu_ctrl.sv
rtl/psopu_dp.sv
rtl/particle_swarm_particle_update_top.sv
tb/sv/particle_swarm_particle_update_top_tb.sv
